/* rtl/core/tps_pkg.sv */
// Shared constants and types of the triangle plane slicer.
package tps_pkg;

  localparam int unsigned CoordWidth = 32;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned TBits      = 32;
  localparam int unsigned EdgeLat    = TBits + 4;
  localparam int unsigned GapCycles  = 3;

  typedef enum logic [2:0] {
    SRC_EDGE12 = 3'd0,
    SRC_EDGE13 = 3'd1,
    SRC_EDGE23 = 3'd2,
    SRC_VERT1  = 3'd3,
    SRC_VERT2  = 3'd4,
    SRC_VERT3  = 3'd5
  } src_e;

  typedef enum logic [2:0] {
    CFG_POINT_X  = 3'd0,
    CFG_POINT_Y  = 3'd1,
    CFG_POINT_Z  = 3'd2,
    CFG_NORMAL_X = 3'd3,
    CFG_NORMAL_Y = 3'd4,
    CFG_NORMAL_Z = 3'd5
  } cfg_reg_e;

endpackage

/* rtl/core/tps_dist.sv */
// Three-stage pipeline forming the signed plane distance of each vertex.
module tps_dist import tps_pkg::*; #(
  parameter int unsigned COORD_WIDTH = CoordWidth
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       valid_i,
  input  logic [2:0][2:0][COORD_WIDTH-1:0]           vert_i,
  input  logic [2:0][COORD_WIDTH-1:0]                point_i,
  input  logic [2:0][COORD_WIDTH-1:0]                normal_i,
  output logic                                       valid_o,
  output logic [2:0][2:0][COORD_WIDTH-1:0]           vert_o,
  output logic [2:0][2*COORD_WIDTH+2:0]              dist_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned DW = 2 * W + 3;

  logic [2:0]                 valid_q;
  logic [2:0][2:0][W:0]       diff_d, diff_q;
  logic [2:0][2:0][2*W:0]     prod_d, prod_q;
  logic [2:0][DW-1:0]         dist_d, dist_q;
  logic [2:0][2:0][W-1:0]     vert1_q, vert2_q, vert3_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        diff_d[i][j] = {vert_i[i][j][W-1], vert_i[i][j]} - {point_i[j][W-1], point_i[j]};
        prod_d[i][j] = $signed(diff_q[i][j]) * $signed(normal_i[j]);
      end
      dist_d[i] = {{2{prod_q[i][0][2*W]}}, prod_q[i][0]}
                + {{2{prod_q[i][1][2*W]}}, prod_q[i][1]}
                + {{2{prod_q[i][2][2*W]}}, prod_q[i][2]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q  <= diff_d;
    prod_q  <= prod_d;
    dist_q  <= dist_d;
    vert1_q <= vert_i;
    vert2_q <= vert1_q;
    vert3_q <= vert2_q;
  end

  assign valid_o = valid_q[2];
  assign vert_o  = vert3_q;
  assign dist_o  = dist_q;

endmodule

/* rtl/core/tps_edge.sv */
// Pipelined edge crossing: bit-per-stage divider followed by interpolation.
module tps_edge import tps_pkg::*; #(
  parameter int unsigned COORD_WIDTH = CoordWidth
) (
  input  logic                                 clk_i,
  input  logic [2*COORD_WIDTH+2:0]             dist_a_i,
  input  logic [2*COORD_WIDTH+2:0]             dist_b_i,
  input  logic [2:0][COORD_WIDTH-1:0]          va_i,
  input  logic [2:0][COORD_WIDTH-1:0]          vb_i,
  output logic [2:0][COORD_WIDTH-1:0]          hit_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned DW = 2 * W + 3;
  localparam int unsigned RW = 2 * W + 5;
  localparam int unsigned MW = W + 1;
  localparam int unsigned PW = TBits + W + 1;

  logic [DW-1:0]        mag_a, mag_b;
  logic [2:0][MW-1:0]   delta, dmag_d;
  logic [2:0]           dneg_d;

  logic [TBits:0][RW-1:0]        rem_q, den_q;
  logic [TBits:0][TBits-1:0]     quo_q;
  logic [TBits:0][2:0][MW-1:0]   dmag_q;
  logic [TBits:0][2:0]           dneg_q;
  logic [TBits:0][2:0][W-1:0]    va_q;
  logic [TBits-1:0][RW-1:0]      rem_d;
  logic [TBits-1:0]              bit_d;

  logic [2:0][PW-1:0]   prod_q;
  logic [2:0]           pneg_q, rneg_q;
  logic [2:0][W-1:0]    pva_q, rva_q, hit_q;
  logic [2:0][MW-1:0]   off_d, off_q;
  logic [2:0][PW:0]     rnd;

  always_comb begin
    mag_a = dist_a_i[DW-1] ? DW'(-dist_a_i) : dist_a_i;
    mag_b = dist_b_i[DW-1] ? DW'(-dist_b_i) : dist_b_i;
    for (int j = 0; j < 3; j++) begin
      delta[j]  = {vb_i[j][W-1], vb_i[j]} - {va_i[j][W-1], va_i[j]};
      dneg_d[j] = delta[j][MW-1];
      dmag_d[j] = dneg_d[j] ? MW'(-delta[j]) : delta[j];
    end
  end

  always_comb begin
    for (int k = 0; k < TBits; k++) begin
      bit_d[k] = {rem_q[k][RW-2:0], 1'b0} >= den_q[k];
      rem_d[k] = bit_d[k] ? {rem_q[k][RW-2:0], 1'b0} - den_q[k] : {rem_q[k][RW-2:0], 1'b0};
    end
    for (int j = 0; j < 3; j++) begin
      rnd[j]   = {1'b0, prod_q[j]} + ((PW+1)'(1) << (TBits - 1));
      off_d[j] = rnd[j][TBits +: MW];
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= RW'(mag_a);
    den_q[0]  <= RW'(mag_a) + RW'(mag_b);
    quo_q[0]  <= '0;
    dmag_q[0] <= dmag_d;
    dneg_q[0] <= dneg_d;
    va_q[0]   <= va_i;
    for (int k = 0; k < TBits; k++) begin
      rem_q[k+1]  <= rem_d[k];
      den_q[k+1]  <= den_q[k];
      quo_q[k+1]  <= {quo_q[k][TBits-2:0], bit_d[k]};
      dmag_q[k+1] <= dmag_q[k];
      dneg_q[k+1] <= dneg_q[k];
      va_q[k+1]   <= va_q[k];
    end
    for (int j = 0; j < 3; j++) begin
      prod_q[j] <= PW'(quo_q[TBits]) * PW'(dmag_q[TBits][j]);
      off_q[j]  <= off_d[j];
      hit_q[j]  <= rneg_q[j] ? rva_q[j] - off_q[j][W-1:0] : rva_q[j] + off_q[j][W-1:0];
    end
    pneg_q <= dneg_q[TBits];
    pva_q  <= va_q[TBits];
    rneg_q <= pneg_q;
    rva_q  <= pva_q;
  end

  assign hit_o = hit_q;

endmodule

/* rtl/core/tps_emit.sv */
// Result sequencer that sends the points of one triangle one per cycle.
module tps_emit import tps_pkg::*; #(
  parameter int unsigned COORD_WIDTH = CoordWidth
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  logic [5:0]                           mask_i,
  input  logic [5:0][2:0][COORD_WIDTH-1:0]     pts_i,
  output logic                                 hit_valid_o,
  output logic [COORD_WIDTH-1:0]               hit_x_o,
  output logic [COORD_WIDTH-1:0]               hit_y_o,
  output logic [COORD_WIDTH-1:0]               hit_z_o,
  output logic [2:0]                           hit_source_o,
  output logic                                 last_of_triangle_o
);

  logic [5:0]                        mask_d, mask_q, pick;
  logic [5:0][2:0][COORD_WIDTH-1:0]  pts_q;
  logic [2:0]                        sel;
  src_e                              src;
  logic                              valid_q, last_q;
  logic [2:0][COORD_WIDTH-1:0]       pt_q;
  src_e                              src_q;

  always_comb begin
    pick = '0;
    sel  = '0;
    src  = SRC_EDGE12;
    for (int k = 5; k >= 0; k--) begin
      if (mask_q[k]) begin
        pick = 6'(1) << k;
        sel  = 3'(k);
        src  = src_e'(3'(k));
      end
    end
    mask_d = valid_i ? mask_i : (mask_q & ~pick);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      mask_q  <= mask_d;
      valid_q <= |mask_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      pts_q <= pts_i;
    end
    pt_q   <= pts_q[sel];
    src_q  <= src;
    last_q <= (mask_q & ~pick) == '0;
  end

  assign hit_valid_o        = valid_q;
  assign hit_x_o            = pt_q[0];
  assign hit_y_o            = pt_q[1];
  assign hit_z_o            = pt_q[2];
  assign hit_source_o       = src_q;
  assign last_of_triangle_o = last_q;

endmodule

/* rtl/core/triangle_plane_slicer_core.sv */
// Top level of the triangle plane slicer.
//
// A triangle transaction is taken when start is high and busy is low; the
// nine vertex coordinates are signed fixed point. The cutting plane (point and
// normal) is written through the configuration channel, which is always
// ready; the user must write it only while no triangle is in flight, which
// the block itself does not enforce. Each triangle gives up to three result
// transactions, one per cycle, each marked by hit_valid_o for a single cycle;
// last_of_triangle_o flags the final one. A triangle that lies wholly on one
// side of the plane gives none. The first result passes through three
// registers of distance arithmetic, the first loaded at the edge that takes
// the triangle, a load register and a 32-stage divider for the edge
// parameter, three interpolation stages and two in the result sequencer.
// After each transaction busy is raised and holds off the next triangle, a
// gap set by the result port that sends up to three points per triangle.
// All stages are pipelined, so triangles overlap in flight. The receiver
// cannot stall. Reset clears every valid bit and loads the plane registers
// with a point at the origin and a unit normal along z.
module triangle_plane_slicer_core import tps_pkg::*; #(
  parameter int unsigned COORD_WIDTH = CoordWidth,
  parameter int unsigned FRAC_BITS   = FracBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [COORD_WIDTH-1:0]  v1_x_i,
  input  logic [COORD_WIDTH-1:0]  v1_y_i,
  input  logic [COORD_WIDTH-1:0]  v1_z_i,
  input  logic [COORD_WIDTH-1:0]  v2_x_i,
  input  logic [COORD_WIDTH-1:0]  v2_y_i,
  input  logic [COORD_WIDTH-1:0]  v2_z_i,
  input  logic [COORD_WIDTH-1:0]  v3_x_i,
  input  logic [COORD_WIDTH-1:0]  v3_y_i,
  input  logic [COORD_WIDTH-1:0]  v3_z_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [2:0]              cfg_index_i,
  input  logic [COORD_WIDTH-1:0]  cfg_data_i,
  output logic                    hit_valid_o,
  output logic [COORD_WIDTH-1:0]  hit_x_o,
  output logic [COORD_WIDTH-1:0]  hit_y_o,
  output logic [COORD_WIDTH-1:0]  hit_z_o,
  output logic [2:0]              hit_source_o,
  output logic                    last_of_triangle_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned DW = 2 * W + 3;
  localparam logic [W-1:0] NormalReset = W'(64'd1 << FRAC_BITS);

  logic                          accept;
  logic [1:0]                    gap_q;
  logic [2:0][W-1:0]             point_q, normal_q;
  logic [2:0][2:0][W-1:0]        vert_in, vert_dist;
  logic                          valid_dist;
  logic [2:0][DW-1:0]            vdist;
  logic [2:0]                    dneg, dzero;
  logic [5:0]                    mask;
  logic [2:0][W-1:0]             hit12, hit13, hit23;
  logic [EdgeLat-1:0]            dl_valid_q;
  logic [EdgeLat-1:0][5:0]       dl_mask_q;
  logic [EdgeLat-1:0][2:0][2:0][W-1:0] dl_vert_q;
  logic [5:0][2:0][W-1:0]        pts;

  assign accept      = start && !busy;
  assign busy        = gap_q != '0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= '0;
    end else if (accept) begin
      gap_q <= 2'(GapCycles - 1);
    end else if (gap_q != '0) begin
      gap_q <= gap_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_q  <= '0;
      normal_q <= {NormalReset, {W{1'b0}}, {W{1'b0}}};
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_POINT_X:  point_q[0]  <= cfg_data_i;
        CFG_POINT_Y:  point_q[1]  <= cfg_data_i;
        CFG_POINT_Z:  point_q[2]  <= cfg_data_i;
        CFG_NORMAL_X: normal_q[0] <= cfg_data_i;
        CFG_NORMAL_Y: normal_q[1] <= cfg_data_i;
        CFG_NORMAL_Z: normal_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign vert_in[0] = {v1_z_i, v1_y_i, v1_x_i};
  assign vert_in[1] = {v2_z_i, v2_y_i, v2_x_i};
  assign vert_in[2] = {v3_z_i, v3_y_i, v3_x_i};

  tps_dist #(.COORD_WIDTH(W)) u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (accept),
    .vert_i   (vert_in),
    .point_i  (point_q),
    .normal_i (normal_q),
    .valid_o  (valid_dist),
    .vert_o   (vert_dist),
    .dist_o   (vdist)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dneg[i]  = vdist[i][DW-1];
      dzero[i] = vdist[i] == '0;
    end
    mask[0] = !dzero[0] && !dzero[1] && (dneg[0] != dneg[1]);
    mask[1] = !dzero[0] && !dzero[2] && (dneg[0] != dneg[2]);
    mask[2] = !dzero[1] && !dzero[2] && (dneg[1] != dneg[2]);
    mask[5:3] = dzero;
  end

  tps_edge #(.COORD_WIDTH(W)) u_edge12 (
    .clk_i(clk_i), .dist_a_i(vdist[0]), .dist_b_i(vdist[1]),
    .va_i(vert_dist[0]), .vb_i(vert_dist[1]), .hit_o(hit12)
  );

  tps_edge #(.COORD_WIDTH(W)) u_edge13 (
    .clk_i(clk_i), .dist_a_i(vdist[0]), .dist_b_i(vdist[2]),
    .va_i(vert_dist[0]), .vb_i(vert_dist[2]), .hit_o(hit13)
  );

  tps_edge #(.COORD_WIDTH(W)) u_edge23 (
    .clk_i(clk_i), .dist_a_i(vdist[1]), .dist_b_i(vdist[2]),
    .va_i(vert_dist[1]), .vb_i(vert_dist[2]), .hit_o(hit23)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dl_valid_q <= '0;
    end else begin
      dl_valid_q <= {dl_valid_q[EdgeLat-2:0], valid_dist};
    end
  end

  always_ff @(posedge clk_i) begin
    dl_mask_q[0] <= mask;
    dl_vert_q[0] <= vert_dist;
    for (int k = 1; k < EdgeLat; k++) begin
      dl_mask_q[k] <= dl_mask_q[k-1];
      dl_vert_q[k] <= dl_vert_q[k-1];
    end
  end

  assign pts[0] = hit12;
  assign pts[1] = hit13;
  assign pts[2] = hit23;
  assign pts[3] = dl_vert_q[EdgeLat-1][0];
  assign pts[4] = dl_vert_q[EdgeLat-1][1];
  assign pts[5] = dl_vert_q[EdgeLat-1][2];

  tps_emit #(.COORD_WIDTH(W)) u_emit (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .valid_i            (dl_valid_q[EdgeLat-1]),
    .mask_i             (dl_mask_q[EdgeLat-1]),
    .pts_i              (pts),
    .hit_valid_o        (hit_valid_o),
    .hit_x_o            (hit_x_o),
    .hit_y_o            (hit_y_o),
    .hit_z_o            (hit_z_o),
    .hit_source_o       (hit_source_o),
    .last_of_triangle_o (last_of_triangle_o)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy) else $error("busy not raised after a triangle transaction");
  a_burst_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_valid_o && !last_of_triangle_o |=> hit_valid_o)
    else $error("result burst ended without a last marker");
  a_source_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_valid_o |-> (hit_source_o == SRC_EDGE12 || hit_source_o == SRC_EDGE13 ||
                     hit_source_o == SRC_EDGE23 || hit_source_o == SRC_VERT1 ||
                     hit_source_o == SRC_VERT2 || hit_source_o == SRC_VERT3))
    else $error("result source out of range");
`endif

endmodule
